// ===== rtl/iee_pkg.sv =====
// Shared types and constants of the integer expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic [6:0] CH_LPAR  = 7'h28;
  localparam logic [6:0] CH_RPAR  = 7'h29;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CH_PCT   = 7'h25;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;

  typedef struct packed {
    logic [6:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
    logic [2:0]         error_code;
    logic [6:0]         error_position;
  } result_t;

  typedef enum logic [3:0] {
    OPR_NONE   = 4'd0,
    OPR_ADD    = 4'd1,
    OPR_SUB    = 4'd2,
    OPR_MUL    = 4'd3,
    OPR_DIV    = 4'd4,
    OPR_MOD    = 4'd5,
    OPR_PAR    = 4'd6,
    OPR_PARNEG = 4'd7
  } opr_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EXP_NUMBER = 3'd1,
    ERR_EXP_RPAR   = 3'd2,
    ERR_DIV_ZERO   = 3'd3,
    ERR_UNEXPECTED = 3'd4,
    ERR_OVERFLOW   = 3'd5
  } err_code_t;

  typedef enum logic [3:0] {
    CC_WS, CC_DIGIT, CC_MINUS, CC_PLUS, CC_MUL, CC_DIV, CC_MOD, CC_LPAR, CC_RPAR, CC_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    PH_OPERAND, PH_NUMBER, PH_AFTER, PH_UNWIND, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CF_RET_NUMBER, CF_RET_RPAR, CF_RET_EOL
  } cf_ret_t;

  typedef enum logic [1:0] {
    RA_RET_OP, RA_RET_RPAR, RA_RET_EOL
  } ra_ret_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_CHAR_INC, DP_NUM_FIRST, DP_NUM_DIGIT, DP_NEG_TOGGLE,
    DP_PUSH_PAR, DP_LOAD_NUM, DP_RD_OPR, DP_POP_LEFT, DP_POP_V, DP_DROP_OPR,
    DP_NEG_V, DP_MUL, DP_NEG_ONE, DP_DIV_START, DP_DIV_DONE, DP_PUSH_V,
    DP_PUSH_OP, DP_ADDSUB, DP_PDEC, DP_ERR, DP_SETPOS, DP_CLEAR, DP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_CHAR_END, ST_UNWIND, ST_UNWIND_POS, ST_AFTER,
    ST_CF_READ, ST_CF_TOP, ST_CF_DROP, ST_CF_MUL, ST_CF_DIVCHK, ST_CF_DIVWAIT,
    ST_CF_PUSH, ST_CF_RET, ST_RA_READ, ST_RA_TOP, ST_RA_LEFT, ST_RA_DROP,
    ST_RA_CALC, ST_RA_PUSH, ST_RA_RET, ST_RP_READ, ST_RP_DROP, ST_RP_PDEC,
    ST_RP_POP, ST_RP_SIGN, ST_EOL_PHASE, ST_EOL_POP, ST_EOL_FIN
  } ctl_state_t;

  typedef struct packed {
    dp_op_t    op;
    err_code_t code;
    logic      pos_inc;
  } dp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        eol;
    logic        pos_ok;
    logic        pos_zero;
    opr_t        top_op;
    logic        opnd_full;
    logic        opnd_ge2;
    logic        opr_full;
    logic        paren_open;
    logic        v_zero;
    logic        v_neg_one;
    logic        div_done;
    logic        result_valid;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/iee_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, C truncation.
`timescale 1ns / 1ps
`default_nettype none
module iee_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_mod,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      result
);

  localparam int CW = $clog2(iee_pkg::DIV_STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   quo;
  logic [31:0]   mag_b;
  logic          neg_q;
  logic          neg_r;
  logic          is_mod_q;
  logic [32:0]   rem_sh;
  logic [32:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, mag_b};
  assign ge     = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(iee_pkg::DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(iee_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quo      <= dividend[31] ? (32'd0 - dividend) : dividend;
      mag_b    <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_q    <= dividend[31] ^ divisor[31];
      neg_r    <= dividend[31];
      is_mod_q <= is_mod;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : rem_sh[31:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign result = is_mod_q ? (neg_r ? (32'd0 - rem) : rem)
                           : (neg_q ? (32'd0 - quo) : quo);

endmodule
`default_nettype wire

// ===== rtl/iee_dp.sv =====
// Datapath: input and result registers, operand and operator stacks, arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module iee_dp #(
  parameter int STACK_DEPTH = 128,
  parameter int LINE_MAX    = 126
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire iee_pkg::in_item_t   item,
  input  wire iee_pkg::dp_cmd_t    cmd,
  input  wire logic                result_ready,
  output iee_pkg::dp_status_t      status,
  output iee_pkg::result_t         result,
  output logic                     result_valid
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CPW = $clog2(LINE_MAX + 1);
  localparam int PW  = CPW + 7;

  logic [31:0]          opnd_mem [STACK_DEPTH];
  iee_pkg::opr_t        opr_mem  [STACK_DEPTH];

  logic [6:0]           c;
  logic                 eol;
  logic [CPW-1:0]       char_pos;
  logic [31:0]          acc;
  logic                 neg;
  logic [31:0]          v;
  logic [31:0]          left;
  iee_pkg::opr_t        top_q;
  logic [SPW-1:0]       opnd_sp;
  logic [SPW-1:0]       opr_sp;
  logic [SPW-1:0]       pdepth;
  iee_pkg::err_code_t   err_code;
  logic [CPW-1:0]       err_pos;

  iee_pkg::char_class_t cls;
  iee_pkg::opr_t        char_op;
  logic [AW-1:0]        opnd_top_idx;
  logic [AW-1:0]        opr_top_idx;
  logic                 opnd_full;
  logic                 opr_full;
  logic                 div_done;
  logic [31:0]          div_result;
  logic [PW-1:0]        pos_ext;
  logic [CPW-1:0]       pos_now;

  always_comb begin
    if (c == iee_pkg::CH_SPACE || c == iee_pkg::CH_TAB) begin
      cls = iee_pkg::CC_WS;
    end else if (c inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]}) begin
      cls = iee_pkg::CC_DIGIT;
    end else if (c == iee_pkg::CH_MINUS) begin
      cls = iee_pkg::CC_MINUS;
    end else if (c == iee_pkg::CH_PLUS) begin
      cls = iee_pkg::CC_PLUS;
    end else if (c == iee_pkg::CH_STAR) begin
      cls = iee_pkg::CC_MUL;
    end else if (c == iee_pkg::CH_SLASH) begin
      cls = iee_pkg::CC_DIV;
    end else if (c == iee_pkg::CH_PCT) begin
      cls = iee_pkg::CC_MOD;
    end else if (c == iee_pkg::CH_LPAR) begin
      cls = iee_pkg::CC_LPAR;
    end else if (c == iee_pkg::CH_RPAR) begin
      cls = iee_pkg::CC_RPAR;
    end else begin
      cls = iee_pkg::CC_OTHER;
    end
  end

  always_comb begin
    case (cls)
      iee_pkg::CC_PLUS:  char_op = iee_pkg::OPR_ADD;
      iee_pkg::CC_MINUS: char_op = iee_pkg::OPR_SUB;
      iee_pkg::CC_MUL:   char_op = iee_pkg::OPR_MUL;
      iee_pkg::CC_DIV:   char_op = iee_pkg::OPR_DIV;
      iee_pkg::CC_MOD:   char_op = iee_pkg::OPR_MOD;
      default:           char_op = iee_pkg::OPR_NONE;
    endcase
  end

  assign opnd_top_idx = AW'(opnd_sp - 1'b1);
  assign opr_top_idx  = AW'(opr_sp - 1'b1);
  assign opnd_full    = (opnd_sp == SPW'(STACK_DEPTH));
  assign opr_full     = (opr_sp == SPW'(STACK_DEPTH));
  assign pos_now      = cmd.pos_inc ? (char_pos + 1'b1) : char_pos;
  assign pos_ext      = PW'(err_pos);

  iee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == iee_pkg::DP_DIV_START),
    .is_mod   (top_q == iee_pkg::OPR_MOD),
    .dividend (left),
    .divisor  (v),
    .done     (div_done),
    .result   (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos     <= '0;
      acc          <= '0;
      neg          <= 1'b0;
      opnd_sp      <= '0;
      opr_sp       <= '0;
      pdepth       <= '0;
      err_code     <= iee_pkg::ERR_NONE;
      err_pos      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (cmd.op)
        iee_pkg::DP_CHAR_INC:   char_pos <= char_pos + 1'b1;
        iee_pkg::DP_NUM_FIRST:  acc <= {28'd0, c[3:0]};
        iee_pkg::DP_NUM_DIGIT:  acc <= (acc << 3) + (acc << 1) + {28'd0, c[3:0]};
        iee_pkg::DP_NEG_TOGGLE: neg <= !neg;
        iee_pkg::DP_PUSH_PAR: begin
          opr_sp <= opr_sp + 1'b1;
          pdepth <= pdepth + 1'b1;
          neg    <= 1'b0;
        end
        iee_pkg::DP_LOAD_NUM:   neg <= 1'b0;
        iee_pkg::DP_POP_LEFT,
        iee_pkg::DP_POP_V: begin
          if (opnd_sp != '0) begin
            opnd_sp <= opnd_sp - 1'b1;
          end
        end
        iee_pkg::DP_DROP_OPR: begin
          if (opr_sp != '0) begin
            opr_sp <= opr_sp - 1'b1;
          end
        end
        iee_pkg::DP_PUSH_V: begin
          if (!opnd_full) begin
            opnd_sp <= opnd_sp + 1'b1;
          end
        end
        iee_pkg::DP_PUSH_OP:    opr_sp <= opr_sp + 1'b1;
        iee_pkg::DP_PDEC:       pdepth <= pdepth - 1'b1;
        iee_pkg::DP_ERR: begin
          err_code <= cmd.code;
          err_pos  <= pos_now;
        end
        iee_pkg::DP_SETPOS:     err_pos <= char_pos + 1'b1;
        iee_pkg::DP_CLEAR,
        iee_pkg::DP_FINISH: begin
          char_pos <= '0;
          acc      <= '0;
          neg      <= 1'b0;
          opnd_sp  <= '0;
          opr_sp   <= '0;
          pdepth   <= '0;
          err_code <= iee_pkg::ERR_NONE;
          err_pos  <= '0;
          if (cmd.op == iee_pkg::DP_FINISH) begin
            result_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      iee_pkg::DP_LATCH: begin
        c   <= item.char_code;
        eol <= item.end_of_line;
      end
      iee_pkg::DP_LOAD_NUM: v <= neg ? (32'd0 - acc) : acc;
      iee_pkg::DP_RD_OPR:   top_q <= (opr_sp == '0) ? iee_pkg::OPR_NONE : opr_mem[opr_top_idx];
      iee_pkg::DP_POP_LEFT: left <= (opnd_sp == '0) ? 32'd0 : opnd_mem[opnd_top_idx];
      iee_pkg::DP_POP_V:    v <= (opnd_sp == '0) ? 32'd0 : opnd_mem[opnd_top_idx];
      iee_pkg::DP_NEG_V:    v <= 32'd0 - v;
      iee_pkg::DP_MUL:      v <= left * v;
      iee_pkg::DP_NEG_ONE:  v <= (top_q == iee_pkg::OPR_DIV) ? (32'd0 - left) : 32'd0;
      iee_pkg::DP_DIV_DONE: v <= div_result;
      iee_pkg::DP_ADDSUB:   v <= (top_q == iee_pkg::OPR_ADD) ? (left + v) : (left - v);
      iee_pkg::DP_PUSH_V: begin
        if (!opnd_full) begin
          opnd_mem[opnd_sp[AW-1:0]] <= v;
        end
      end
      iee_pkg::DP_PUSH_OP:  opr_mem[opr_sp[AW-1:0]] <= char_op;
      iee_pkg::DP_PUSH_PAR: opr_mem[opr_sp[AW-1:0]] <= neg ? iee_pkg::OPR_PARNEG
                                                             : iee_pkg::OPR_PAR;
      iee_pkg::DP_FINISH: begin
        if (err_code != iee_pkg::ERR_NONE) begin
          result.value          <= '0;
          result.ok             <= 1'b0;
          result.error_code     <= err_code;
          result.error_position <= pos_ext[6:0];
        end else begin
          result.value          <= v;
          result.ok             <= 1'b1;
          result.error_code     <= iee_pkg::ERR_NONE;
          result.error_position <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    status.cls          = cls;
    status.eol          = eol;
    status.pos_ok       = (char_pos < CPW'(LINE_MAX));
    status.pos_zero     = (char_pos == '0);
    status.top_op       = top_q;
    status.opnd_full    = opnd_full;
    status.opnd_ge2     = (opnd_sp >= SPW'(2));
    status.opr_full     = opr_full;
    status.paren_open   = (pdepth != '0);
    status.v_zero       = (v == 32'd0);
    status.v_neg_one    = (v == 32'hFFFF_FFFF);
    status.div_done     = div_done;
    status.result_valid = result_valid;
  end

endmodule
`default_nettype wire

// ===== rtl/iee_ctrl.sv =====
// Controller: parse phase and the sequencer that drives the datapath.
`timescale 1ns / 1ps
`default_nettype none
module iee_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire logic                item_eol,
  input  wire iee_pkg::dp_status_t status,
  output logic                     item_ready,
  output iee_pkg::dp_cmd_t         cmd
);

  iee_pkg::ctl_state_t state, state_next;
  iee_pkg::phase_t     phase, phase_next;
  iee_pkg::cf_ret_t    cf_ret, cf_ret_next;
  iee_pkg::ra_ret_t    ra_ret, ra_ret_next;
  iee_pkg::err_code_t  cf_err, cf_err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= iee_pkg::ST_IDLE;
      phase  <= iee_pkg::PH_OPERAND;
      cf_ret <= iee_pkg::CF_RET_NUMBER;
      ra_ret <= iee_pkg::RA_RET_OP;
      cf_err <= iee_pkg::ERR_NONE;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      cf_ret <= cf_ret_next;
      ra_ret <= ra_ret_next;
      cf_err <= cf_err_next;
    end
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    cf_ret_next = cf_ret;
    ra_ret_next = ra_ret;
    cf_err_next = cf_err;
    cmd.op      = iee_pkg::DP_NOP;
    cmd.code    = iee_pkg::ERR_NONE;
    cmd.pos_inc = 1'b0;
    item_ready  = (state == iee_pkg::ST_IDLE) && (!item_eol || !status.result_valid);

    case (state)
      iee_pkg::ST_IDLE: begin
        if (item_valid && item_ready) begin
          cmd.op     = iee_pkg::DP_LATCH;
          state_next = iee_pkg::ST_DISPATCH;
        end
      end

      iee_pkg::ST_DISPATCH: begin
        if (status.eol) begin
          if (status.pos_zero) begin
            cmd.op     = iee_pkg::DP_CLEAR;
            phase_next = iee_pkg::PH_OPERAND;
            state_next = iee_pkg::ST_IDLE;
          end else if (phase == iee_pkg::PH_NUMBER) begin
            cmd.op      = iee_pkg::DP_LOAD_NUM;
            cf_ret_next = iee_pkg::CF_RET_EOL;
            state_next  = iee_pkg::ST_CF_READ;
          end else begin
            state_next = iee_pkg::ST_EOL_PHASE;
          end
        end else if (!status.pos_ok) begin
          state_next = iee_pkg::ST_IDLE;
        end else begin
          state_next = iee_pkg::ST_CHAR_END;
          case (phase)
            iee_pkg::PH_OPERAND: begin
              case (status.cls)
                iee_pkg::CC_WS: ;
                iee_pkg::CC_MINUS: cmd.op = iee_pkg::DP_NEG_TOGGLE;
                iee_pkg::CC_LPAR: begin
                  if (status.opr_full) begin
                    cmd.op     = iee_pkg::DP_ERR;
                    cmd.code   = iee_pkg::ERR_OVERFLOW;
                    phase_next = iee_pkg::PH_DONE;
                  end else begin
                    cmd.op = iee_pkg::DP_PUSH_PAR;
                  end
                end
                iee_pkg::CC_DIGIT: begin
                  cmd.op     = iee_pkg::DP_NUM_FIRST;
                  phase_next = iee_pkg::PH_NUMBER;
                end
                default: begin
                  cmd.op     = iee_pkg::DP_ERR;
                  cmd.code   = iee_pkg::ERR_EXP_NUMBER;
                  phase_next = iee_pkg::PH_UNWIND;
                  state_next = iee_pkg::ST_UNWIND;
                end
              endcase
            end
            iee_pkg::PH_NUMBER: begin
              if (status.cls == iee_pkg::CC_DIGIT) begin
                cmd.op = iee_pkg::DP_NUM_DIGIT;
              end else begin
                cmd.op      = iee_pkg::DP_LOAD_NUM;
                cf_ret_next = iee_pkg::CF_RET_NUMBER;
                state_next  = iee_pkg::ST_CF_READ;
              end
            end
            iee_pkg::PH_AFTER:  state_next = iee_pkg::ST_AFTER;
            iee_pkg::PH_UNWIND: state_next = iee_pkg::ST_UNWIND;
            default: ;
          endcase
        end
      end

      iee_pkg::ST_UNWIND: begin
        if (status.cls == iee_pkg::CC_WS) begin
          cmd.op     = iee_pkg::DP_SETPOS;
          state_next = iee_pkg::ST_CHAR_END;
        end else if (status.cls == iee_pkg::CC_RPAR && status.paren_open) begin
          cmd.op     = iee_pkg::DP_PDEC;
          state_next = iee_pkg::ST_UNWIND_POS;
        end else begin
          phase_next = iee_pkg::PH_DONE;
          state_next = iee_pkg::ST_CHAR_END;
        end
      end

      iee_pkg::ST_UNWIND_POS: begin
        cmd.op     = iee_pkg::DP_SETPOS;
        state_next = iee_pkg::ST_CHAR_END;
      end

      iee_pkg::ST_CHAR_END: begin
        cmd.op     = iee_pkg::DP_CHAR_INC;
        state_next = iee_pkg::ST_IDLE;
      end

      iee_pkg::ST_AFTER: begin
        state_next = iee_pkg::ST_CHAR_END;
        case (status.cls)
          iee_pkg::CC_WS: ;
          iee_pkg::CC_MUL, iee_pkg::CC_DIV, iee_pkg::CC_MOD: begin
            if (status.opr_full) begin
              cmd.op     = iee_pkg::DP_ERR;
              cmd.code   = iee_pkg::ERR_OVERFLOW;
              phase_next = iee_pkg::PH_DONE;
            end else begin
              cmd.op     = iee_pkg::DP_PUSH_OP;
              phase_next = iee_pkg::PH_OPERAND;
            end
          end
          iee_pkg::CC_PLUS, iee_pkg::CC_MINUS: begin
            ra_ret_next = iee_pkg::RA_RET_OP;
            state_next  = iee_pkg::ST_RA_READ;
          end
          default: begin
            if (status.cls == iee_pkg::CC_RPAR && status.paren_open) begin
              ra_ret_next = iee_pkg::RA_RET_RPAR;
              state_next  = iee_pkg::ST_RA_READ;
            end else begin
              cmd.op     = iee_pkg::DP_ERR;
              cmd.code   = (status.paren_open && status.cls != iee_pkg::CC_RPAR)
                           ? iee_pkg::ERR_EXP_RPAR : iee_pkg::ERR_UNEXPECTED;
              phase_next = iee_pkg::PH_DONE;
            end
          end
        endcase
      end

      iee_pkg::ST_CF_READ: begin
        cmd.op     = iee_pkg::DP_RD_OPR;
        state_next = iee_pkg::ST_CF_TOP;
      end

      iee_pkg::ST_CF_TOP: begin
        if (status.top_op == iee_pkg::OPR_MUL || status.top_op == iee_pkg::OPR_DIV ||
            status.top_op == iee_pkg::OPR_MOD) begin
          cmd.op     = iee_pkg::DP_POP_LEFT;
          state_next = iee_pkg::ST_CF_DROP;
        end else begin
          state_next = iee_pkg::ST_CF_PUSH;
        end
      end

      iee_pkg::ST_CF_DROP: begin
        cmd.op     = iee_pkg::DP_DROP_OPR;
        state_next = (status.top_op == iee_pkg::OPR_MUL) ? iee_pkg::ST_CF_MUL
                                                         : iee_pkg::ST_CF_DIVCHK;
      end

      iee_pkg::ST_CF_MUL: begin
        cmd.op     = iee_pkg::DP_MUL;
        state_next = iee_pkg::ST_CF_PUSH;
      end

      iee_pkg::ST_CF_DIVCHK: begin
        if (status.v_zero) begin
          cf_err_next = iee_pkg::ERR_DIV_ZERO;
          state_next  = iee_pkg::ST_CF_RET;
        end else if (status.v_neg_one) begin
          cmd.op     = iee_pkg::DP_NEG_ONE;
          state_next = iee_pkg::ST_CF_PUSH;
        end else begin
          cmd.op     = iee_pkg::DP_DIV_START;
          state_next = iee_pkg::ST_CF_DIVWAIT;
        end
      end

      iee_pkg::ST_CF_DIVWAIT: begin
        if (status.div_done) begin
          cmd.op     = iee_pkg::DP_DIV_DONE;
          state_next = iee_pkg::ST_CF_PUSH;
        end
      end

      iee_pkg::ST_CF_PUSH: begin
        if (status.opnd_full) begin
          cf_err_next = iee_pkg::ERR_OVERFLOW;
        end else begin
          cmd.op      = iee_pkg::DP_PUSH_V;
          cf_err_next = iee_pkg::ERR_NONE;
        end
        state_next = iee_pkg::ST_CF_RET;
      end

      iee_pkg::ST_CF_RET: begin
        case (cf_ret)
          iee_pkg::CF_RET_NUMBER: begin
            case (cf_err)
              iee_pkg::ERR_DIV_ZERO: begin
                cmd.op     = iee_pkg::DP_ERR;
                cmd.code   = iee_pkg::ERR_DIV_ZERO;
                phase_next = iee_pkg::PH_UNWIND;
                state_next = iee_pkg::ST_UNWIND;
              end
              iee_pkg::ERR_OVERFLOW: begin
                cmd.op     = iee_pkg::DP_ERR;
                cmd.code   = iee_pkg::ERR_OVERFLOW;
                phase_next = iee_pkg::PH_DONE;
                state_next = iee_pkg::ST_CHAR_END;
              end
              default: begin
                phase_next = iee_pkg::PH_AFTER;
                state_next = iee_pkg::ST_AFTER;
              end
            endcase
          end
          iee_pkg::CF_RET_RPAR: begin
            state_next = iee_pkg::ST_CHAR_END;
            case (cf_err)
              iee_pkg::ERR_DIV_ZERO: begin
                cmd.op      = iee_pkg::DP_ERR;
                cmd.code    = iee_pkg::ERR_DIV_ZERO;
                cmd.pos_inc = 1'b1;
                phase_next  = iee_pkg::PH_UNWIND;
              end
              iee_pkg::ERR_OVERFLOW: begin
                cmd.op     = iee_pkg::DP_ERR;
                cmd.code   = iee_pkg::ERR_OVERFLOW;
                phase_next = iee_pkg::PH_DONE;
              end
              default: ;
            endcase
          end
          default: begin
            if (cf_err == iee_pkg::ERR_NONE) begin
              phase_next = iee_pkg::PH_AFTER;
              state_next = iee_pkg::ST_EOL_PHASE;
            end else begin
              cmd.op     = iee_pkg::DP_ERR;
              cmd.code   = cf_err;
              phase_next = iee_pkg::PH_DONE;
              state_next = iee_pkg::ST_EOL_FIN;
            end
          end
        endcase
      end

      iee_pkg::ST_RA_READ: begin
        cmd.op     = iee_pkg::DP_RD_OPR;
        state_next = iee_pkg::ST_RA_TOP;
      end

      iee_pkg::ST_RA_TOP: begin
        if ((status.top_op == iee_pkg::OPR_ADD || status.top_op == iee_pkg::OPR_SUB) &&
            status.opnd_ge2) begin
          cmd.op     = iee_pkg::DP_POP_V;
          state_next = iee_pkg::ST_RA_LEFT;
        end else begin
          state_next = iee_pkg::ST_RA_RET;
        end
      end

      iee_pkg::ST_RA_LEFT: begin
        cmd.op     = iee_pkg::DP_POP_LEFT;
        state_next = iee_pkg::ST_RA_DROP;
      end

      iee_pkg::ST_RA_DROP: begin
        cmd.op     = iee_pkg::DP_DROP_OPR;
        state_next = iee_pkg::ST_RA_CALC;
      end

      iee_pkg::ST_RA_CALC: begin
        cmd.op     = iee_pkg::DP_ADDSUB;
        state_next = iee_pkg::ST_RA_PUSH;
      end

      iee_pkg::ST_RA_PUSH: begin
        cmd.op     = iee_pkg::DP_PUSH_V;
        state_next = iee_pkg::ST_RA_RET;
      end

      iee_pkg::ST_RA_RET: begin
        case (ra_ret)
          iee_pkg::RA_RET_OP: begin
            state_next = iee_pkg::ST_CHAR_END;
            if (status.opr_full) begin
              cmd.op     = iee_pkg::DP_ERR;
              cmd.code   = iee_pkg::ERR_OVERFLOW;
              phase_next = iee_pkg::PH_DONE;
            end else begin
              cmd.op     = iee_pkg::DP_PUSH_OP;
              phase_next = iee_pkg::PH_OPERAND;
            end
          end
          iee_pkg::RA_RET_RPAR: state_next = iee_pkg::ST_RP_READ;
          default:              state_next = iee_pkg::ST_EOL_POP;
        endcase
      end

      iee_pkg::ST_RP_READ: begin
        cmd.op     = iee_pkg::DP_RD_OPR;
        state_next = iee_pkg::ST_RP_DROP;
      end

      iee_pkg::ST_RP_DROP: begin
        cmd.op     = iee_pkg::DP_DROP_OPR;
        state_next = iee_pkg::ST_RP_PDEC;
      end

      iee_pkg::ST_RP_PDEC: begin
        cmd.op     = iee_pkg::DP_PDEC;
        state_next = iee_pkg::ST_RP_POP;
      end

      iee_pkg::ST_RP_POP: begin
        cmd.op     = iee_pkg::DP_POP_V;
        state_next = iee_pkg::ST_RP_SIGN;
      end

      iee_pkg::ST_RP_SIGN: begin
        if (status.top_op == iee_pkg::OPR_PARNEG) begin
          cmd.op = iee_pkg::DP_NEG_V;
        end
        cf_ret_next = iee_pkg::CF_RET_RPAR;
        state_next  = iee_pkg::ST_CF_READ;
      end

      iee_pkg::ST_EOL_PHASE: begin
        case (phase)
          iee_pkg::PH_OPERAND: begin
            cmd.op     = iee_pkg::DP_ERR;
            cmd.code   = iee_pkg::ERR_EXP_NUMBER;
            phase_next = iee_pkg::PH_DONE;
            state_next = iee_pkg::ST_EOL_FIN;
          end
          iee_pkg::PH_AFTER: begin
            if (status.paren_open) begin
              cmd.op     = iee_pkg::DP_ERR;
              cmd.code   = iee_pkg::ERR_EXP_RPAR;
              phase_next = iee_pkg::PH_DONE;
              state_next = iee_pkg::ST_EOL_FIN;
            end else begin
              ra_ret_next = iee_pkg::RA_RET_EOL;
              state_next  = iee_pkg::ST_RA_READ;
            end
          end
          default: state_next = iee_pkg::ST_EOL_FIN;
        endcase
      end

      iee_pkg::ST_EOL_POP: begin
        cmd.op     = iee_pkg::DP_POP_V;
        state_next = iee_pkg::ST_EOL_FIN;
      end

      iee_pkg::ST_EOL_FIN: begin
        cmd.op     = iee_pkg::DP_FINISH;
        phase_next = iee_pkg::PH_OPERAND;
        state_next = iee_pkg::ST_IDLE;
      end

      default: state_next = iee_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/integer_expression_evaluator.sv =====
// Top level of the streaming integer expression evaluator.
// The item channel carries one ASCII character a beat, or an end-of-line beat
// that closes the expression. The result channel carries one beat for each
// non-empty line: the value, ok, an error code and the error position.
// A plain character beat is latched, dispatched and counted before the next ready.
// A character that completes a factor or closes a parenthesis walks the
// operator and operand stacks one memory access a cycle, and waits while the
// bit-serial divider runs for each division or modulo; a closing parenthesis
// can finish two of them. The end-of-line beat takes a similar path and the
// result appears in the output register when the sequencer finishes.
// After reset the stacks are empty and the block waits for the first character.
// The result register holds a finished beat while the receiver stalls; new
// characters are still taken, only the next end-of-line beat waits until the
// result register is free.
`timescale 1ns / 1ps
`default_nettype none
module integer_expression_evaluator #(
  parameter int STACK_DEPTH = 128,
  parameter int LINE_MAX    = 126
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire iee_pkg::in_item_t item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output iee_pkg::result_t       result
);

  iee_pkg::dp_cmd_t    cmd;
  iee_pkg::dp_status_t status;

  iee_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_eol   (item.end_of_line),
    .status     (status),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  iee_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_MAX    (LINE_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .result_ready (result_ready),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

  a_eol_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.end_of_line |-> !result_valid)
    else $error("end-of-line beat accepted while a result is pending");

  a_ok_is_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.ok |->
      result.error_code == iee_pkg::ERR_NONE && result.error_position == 7'd0)
    else $error("ok result carries an error");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ok |->
      result.value == 32'sd0 && result.error_code != iee_pkg::ERR_NONE)
    else $error("failed result carries a value or no error code");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> $past(cmd.op, 33) == iee_pkg::DP_DIV_START)
    else $error("divider finished without a matching start");

endmodule
`default_nettype wire
